>>> design/ffbt_pkg.sv
// ----------------------------------------------------------------------------
// ffbt_pkg: shared types and constants of the boundary-tag allocator
// Tag layout, heap geometry, opcodes and the queue entry between the
// front and the back of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffbt_pkg;

  // Heap geometry in bytes.
  localparam int HEAP_BYTES  = 1024;
  localparam int TAG_BYTES   = 16;
  localparam int PAYLOAD_MAX = HEAP_BYTES - 2 * TAG_BYTES;
  localparam int WALK_LIMIT  = HEAP_BYTES / (2 * TAG_BYTES) + 1;

  // Field and internal widths.
  localparam int ADDR_W = 10;
  localparam int SIZE_W = 10;
  localparam int OFS_W  = 12;
  localparam int CNT_W  = 6;

  typedef logic [OFS_W-1:0] ofs_t;

  localparam ofs_t HEAP_OFS = ofs_t'(HEAP_BYTES);
  localparam ofs_t TAG_OFS  = ofs_t'(TAG_BYTES);
  localparam ofs_t PAIR_OFS = ofs_t'(2 * TAG_BYTES);
  localparam ofs_t MAX_OFS  = ofs_t'(PAYLOAD_MAX);
  localparam logic [CNT_W-1:0] WALK_CNT = CNT_W'(WALK_LIMIT);

  // Operation codes of a request.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // One boundary tag: free flag and payload size.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } tag_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] rel;
    logic              oversize;
  } item_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

>>> design/ffbt_if.sv
// ----------------------------------------------------------------------------
// ffbt_if: request and response channels of the allocator
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffbt_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [9:0] request_size;
  logic [9:0] release_offset;

  modport source (output valid, output opcode, output request_size,
                  output release_offset, input ready);
  modport sink (input valid, input opcode, input request_size,
                input release_offset, output ready);
endinterface

interface ffbt_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [9:0] payload_offset;

  modport source (output valid, output granted, output payload_offset, input ready);
  modport sink (input valid, input granted, input payload_offset, output ready);
endinterface

`default_nettype wire

>>> design/ffbt_front.sv
// ----------------------------------------------------------------------------
// ffbt_front: request intake and classification
// Accepts requests, flags oversize allocations and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  ffbt_req_if.sink              req,
  input  wire logic             pop,
  output ffbt_pkg::qhead_t      head
);

  ffbt_pkg::item_t slot [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;
  ffbt_pkg::item_t incoming;

  // Classify the incoming request.
  always_comb begin
    incoming.op       = ffbt_pkg::op_t'(req.opcode);
    incoming.size     = req.request_size;
    incoming.rel      = req.release_offset;
    incoming.oversize = ffbt_pkg::ofs_t'(req.request_size) > ffbt_pkg::MAX_OFS;
  end

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rptr];

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= incoming;
  end

endmodule

`default_nettype wire

>>> design/ffbt_back.sv
// ----------------------------------------------------------------------------
// ffbt_back: block walker and tag writer
// Holds the tag memory, walks the implicit block list one header per
// cycle, writes split or merge tags and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ffbt_pkg::qhead_t      head,
  output logic                  pop,
  ffbt_rsp_if.source            rsp
);

  typedef enum logic [8:0] {
    S_INIT0 = 9'b000000001,
    S_INIT1 = 9'b000000010,
    S_IDLE  = 9'b000000100,
    S_ACHK  = 9'b000001000,
    S_FCHK  = 9'b000010000,
    S_FRGT  = 9'b000100000,
    S_FLFT  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [ffbt_pkg::ADDR_W-1:0] addr;
    ffbt_pkg::tag_t              tag;
  } wr_t;

  state_t state, state_next;

  // Tag memory.
  ffbt_pkg::tag_t              mem [ffbt_pkg::HEAP_BYTES];
  ffbt_pkg::tag_t              rdata;
  logic [ffbt_pkg::ADDR_W-1:0] ra;
  logic                        we;
  logic [ffbt_pkg::ADDR_W-1:0] wa;
  ffbt_pkg::tag_t              wd;

  // Walk registers.
  logic [ffbt_pkg::ADDR_W-1:0] b, b_next;
  logic [ffbt_pkg::CNT_W-1:0]  n, n_next;
  logic [ffbt_pkg::SIZE_W-1:0] sz, sz_next;
  logic [ffbt_pkg::SIZE_W-1:0] want;
  logic [ffbt_pkg::ADDR_W-1:0] rel;

  // Pending write list and its result.
  wr_t        wq [4];
  wr_t        wq_next [4];
  logic [1:0] widx, widx_next;
  logic [1:0] wlast, wlast_next;
  logic       pend_gr, pend_gr_next;
  logic [ffbt_pkg::ADDR_W-1:0] pend_pay, pend_pay_next;

  // Result register.
  logic       res_valid;
  logic       res_gr;
  logic [ffbt_pkg::ADDR_W-1:0] res_pay;
  logic       finish;
  logic       fin_gr;
  logic [ffbt_pkg::ADDR_W-1:0] fin_pay;

  // Arithmetic on the tag just read.
  ffbt_pkg::ofs_t r_sz, b_o, sz_o, want_o, rel_o, nb, rem, nx, pv, mrg;
  logic [ffbt_pkg::CNT_W-1:0] cnt_inc;
  logic walk_end, left_ok;

  assign rsp.valid          = res_valid;
  assign rsp.granted        = res_gr;
  assign rsp.payload_offset = res_pay;

  always_comb begin
    r_sz     = ffbt_pkg::ofs_t'(rdata.size);
    b_o      = ffbt_pkg::ofs_t'(b);
    sz_o     = ffbt_pkg::ofs_t'(sz);
    want_o   = ffbt_pkg::ofs_t'(want);
    rel_o    = ffbt_pkg::ofs_t'(rel);
    nb       = b_o + ffbt_pkg::PAIR_OFS + r_sz;
    rem      = r_sz - want_o;
    nx       = b_o + ffbt_pkg::PAIR_OFS + sz_o;
    pv       = b_o - ffbt_pkg::PAIR_OFS - r_sz;
    mrg      = r_sz + sz_o + ffbt_pkg::PAIR_OFS;
    cnt_inc  = n + 1'b1;
    walk_end = (cnt_inc >= ffbt_pkg::WALK_CNT) || (nb >= ffbt_pkg::HEAP_OFS);
    left_ok  = (b_o >= ffbt_pkg::PAIR_OFS) && rdata.free &&
               (r_sz + ffbt_pkg::PAIR_OFS <= b_o);
  end

  // Sequencer.
  always_comb begin
    state_next    = state;
    b_next        = b;
    n_next        = n;
    sz_next       = sz;
    widx_next     = widx;
    wlast_next    = wlast;
    pend_gr_next  = pend_gr;
    pend_pay_next = pend_pay;
    for (int i = 0; i < 4; i++) wq_next[i] = wq[i];
    ra      = b;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    pop     = 1'b0;
    finish  = 1'b0;
    fin_gr  = 1'b0;
    fin_pay = '0;

    unique case (state)
      S_INIT0: begin
        we         = 1'b1;
        wa         = '0;
        wd.free    = 1'b1;
        wd.size    = ffbt_pkg::SIZE_W'(ffbt_pkg::PAYLOAD_MAX);
        state_next = S_INIT1;
      end
      S_INIT1: begin
        we         = 1'b1;
        wa         = ffbt_pkg::ADDR_W'(ffbt_pkg::TAG_BYTES + ffbt_pkg::PAYLOAD_MAX);
        wd.free    = 1'b1;
        wd.size    = ffbt_pkg::SIZE_W'(ffbt_pkg::PAYLOAD_MAX);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (head.valid && !res_valid) begin
          pop = 1'b1;
          if (head.item.op == ffbt_pkg::OP_ALLOC && head.item.oversize) begin
            finish = 1'b1;
          end else begin
            b_next     = '0;
            n_next     = '0;
            ra         = '0;
            state_next = (head.item.op == ffbt_pkg::OP_ALLOC) ? S_ACHK : S_FCHK;
          end
        end
      end
      // First-fit check of the header at b; the next header is read meanwhile.
      S_ACHK: begin
        ra = nb[ffbt_pkg::ADDR_W-1:0];
        if (rdata.free && want <= rdata.size) begin
          pend_gr_next  = 1'b1;
          pend_pay_next = ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS);
          widx_next     = '0;
          state_next    = S_WRITE;
          if (rem >= ffbt_pkg::PAIR_OFS) begin
            wq_next[0] = '{addr: b, tag: '{free: 1'b0, size: want}};
            wq_next[1] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS + want_o),
                           tag: '{free: 1'b0, size: want}};
            wq_next[2] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::PAIR_OFS + want_o),
                           tag: '{free: 1'b1,
                                  size: ffbt_pkg::SIZE_W'(rem - ffbt_pkg::PAIR_OFS)}};
            wq_next[3] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS + r_sz),
                           tag: '{free: 1'b1,
                                  size: ffbt_pkg::SIZE_W'(rem - ffbt_pkg::PAIR_OFS)}};
            wlast_next = 2'd3;
          end else begin
            wq_next[0] = '{addr: b, tag: '{free: 1'b0, size: rdata.size}};
            wq_next[1] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS + r_sz),
                           tag: '{free: 1'b0, size: rdata.size}};
            wlast_next = 2'd1;
          end
        end else if (walk_end) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          b_next = nb[ffbt_pkg::ADDR_W-1:0];
          n_next = cnt_inc;
        end
      end
      // Search for the block whose payload starts at the released offset.
      S_FCHK: begin
        ra = nb[ffbt_pkg::ADDR_W-1:0];
        priority if (b_o + ffbt_pkg::TAG_OFS == rel_o) begin
          if (rdata.free) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            sz_next    = rdata.size;
            state_next = S_FRGT;
          end
        end else if (b_o + ffbt_pkg::TAG_OFS > rel_o || walk_end) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          b_next = nb[ffbt_pkg::ADDR_W-1:0];
          n_next = cnt_inc;
        end
      end
      // Right neighbour header is in rdata; read the left neighbour footer.
      S_FRGT: begin
        ra = ffbt_pkg::ADDR_W'(b_o - ffbt_pkg::TAG_OFS);
        if (nx < ffbt_pkg::HEAP_OFS && rdata.free) begin
          sz_next = ffbt_pkg::SIZE_W'(sz_o + r_sz + ffbt_pkg::PAIR_OFS);
        end
        state_next = S_FLFT;
      end
      // Left neighbour footer is in rdata; queue the merged block tags.
      S_FLFT: begin
        pend_gr_next  = 1'b1;
        pend_pay_next = '0;
        widx_next     = '0;
        wlast_next    = 2'd1;
        if (left_ok) begin
          wq_next[0] = '{addr: ffbt_pkg::ADDR_W'(pv),
                         tag: '{free: 1'b1, size: ffbt_pkg::SIZE_W'(mrg)}};
          wq_next[1] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS + sz_o),
                         tag: '{free: 1'b1, size: ffbt_pkg::SIZE_W'(mrg)}};
        end else begin
          wq_next[0] = '{addr: b, tag: '{free: 1'b1, size: sz}};
          wq_next[1] = '{addr: ffbt_pkg::ADDR_W'(b_o + ffbt_pkg::TAG_OFS + sz_o),
                         tag: '{free: 1'b1, size: sz}};
        end
        state_next = S_WRITE;
      end
      // One tag write per cycle, then post the result.
      S_WRITE: begin
        we        = 1'b1;
        wa        = wq[widx].addr;
        wd        = wq[widx].tag;
        widx_next = widx + 1'b1;
        if (widx == wlast) begin
          finish     = 1'b1;
          fin_gr     = pend_gr;
          fin_pay    = pend_pay;
          state_next = S_IDLE;
        end
      end
      S_SPARE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    b        <= b_next;
    n        <= n_next;
    sz       <= sz_next;
    widx     <= widx_next;
    wlast    <= wlast_next;
    pend_gr  <= pend_gr_next;
    pend_pay <= pend_pay_next;
    for (int i = 0; i < 4; i++) wq[i] <= wq_next[i];
    if (pop) begin
      want <= head.item.size;
      rel  <= head.item.rel;
    end
    if (finish) begin
      res_gr  <= fin_gr;
      res_pay <= fin_pay;
    end
  end

  // Tag memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

endmodule

`default_nettype wire

>>> design/first_fit_boundary_tag_allocator_unit.sv
// Init: after reset, S_INIT0 then S_INIT1 tag the free block; requests queue meanwhile.
// Allocate: a first-fit walk over the headers, plus 2 tag writes (4 on a split).
// Free: a walk to the released block, 2 neighbor reads, then 2 tag writes.
// Requests: one at a time, paced by the header walk through the single read port
// of the tag memory.
// Reset: synchronous; clears the queue, the result register and the sequencer.
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit: first-fit heap allocator
// Front queues requests, back walks boundary tags and returns results.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_boundary_tag_allocator_unit (
  input  wire logic clk,
  input  wire logic rst,
  ffbt_req_if.sink  req,
  ffbt_rsp_if.source rsp
);

  ffbt_pkg::qhead_t head;
  logic             pop;

  // Request intake and queue.
  ffbt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  // Walker, tag memory and result register.
  ffbt_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

>>> design/ffbt_checker.sv
// ----------------------------------------------------------------------------
// ffbt_checker: port-level checks of the allocator
// Watches the response channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_granted,
  input wire logic [9:0] rsp_payload_offset
);

  // A stalled result holds its fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
    $stable(rsp_payload_offset))
    else $error("stalled result changed");

  // A refused request reports offset zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_granted |-> rsp_payload_offset == 10'd0)
    else $error("failed request with nonzero offset");

  // A nonzero payload offset always lies past a header tag.
  a_past_hdr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload_offset != 10'd0 |->
    rsp_payload_offset >= 10'(ffbt_pkg::TAG_BYTES))
    else $error("payload offset inside a header");

  // No result right after reset.
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown after reset");

endmodule

bind first_fit_boundary_tag_allocator_unit ffbt_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_granted        (rsp.granted),
  .rsp_payload_offset (rsp.payload_offset)
);

`default_nettype wire
